// ===== sv/sstb_pkg.sv =====
// ----------------------------------------------------------------------------
// sstb_pkg
// shared types and constants for the size string to byte count parser
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sstb_pkg;

  localparam int unsigned FRAC_DIGITS = 10;
  localparam int unsigned COUNT_W     = 63;
  localparam int unsigned FRAC_W      = 64;
  localparam int unsigned DIGCNT_W    = 5;
  localparam int unsigned SHIFT_W     = 5;
  localparam int unsigned REM_W       = 61;
  localparam int unsigned QUO_W       = 31;
  localparam int unsigned STEP_W      = 7;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned OUT_DATA_W  = 72;

  localparam logic [COUNT_W-1:0] MAX_SIZE_RST = 63'd1073741824;

  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UK    = 8'h4B;
  localparam logic [CHAR_W-1:0] CH_LK    = 8'h6B;
  localparam logic [CHAR_W-1:0] CH_UM    = 8'h4D;
  localparam logic [CHAR_W-1:0] CH_LM    = 8'h6D;
  localparam logic [CHAR_W-1:0] CH_UG    = 8'h47;
  localparam logic [CHAR_W-1:0] CH_LG    = 8'h67;

  localparam logic [SHIFT_W-1:0] SHIFT_K = 5'd10;
  localparam logic [SHIFT_W-1:0] SHIFT_M = 5'd20;
  localparam logic [SHIFT_W-1:0] SHIFT_G = 5'd30;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGNED,
    PH_WHOLE,
    PH_DOT,
    PH_FRAC,
    PH_SUFFIX
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_MALFORMED = 3'd1,
    ST_NOT_POS   = 3'd2,
    ST_FRAC_NOSF = 3'd3,
    ST_TOO_LARGE = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_DIV,
    FSM_FIN
  } fsm_e;

  function automatic logic [FRAC_W-1:0] pow10(input logic [DIGCNT_W-1:0] n);
    logic [FRAC_W-1:0] p;
    begin
      case (n)
        5'd0:    p = 64'd1;
        5'd1:    p = 64'd10;
        5'd2:    p = 64'd100;
        5'd3:    p = 64'd1000;
        5'd4:    p = 64'd10000;
        5'd5:    p = 64'd100000;
        5'd6:    p = 64'd1000000;
        5'd7:    p = 64'd10000000;
        5'd8:    p = 64'd100000000;
        5'd9:    p = 64'd1000000000;
        5'd10:   p = 64'd10000000000;
        5'd11:   p = 64'd100000000000;
        5'd12:   p = 64'd1000000000000;
        5'd13:   p = 64'd10000000000000;
        5'd14:   p = 64'd100000000000000;
        5'd15:   p = 64'd1000000000000000;
        5'd16:   p = 64'd10000000000000000;
        5'd17:   p = 64'd100000000000000000;
        5'd18:   p = 64'd1000000000000000000;
        default: p = 64'd1;
      endcase
      return p;
    end
  endfunction

endpackage

// ===== sv/size_string_to_bytes.sv =====
// ----------------------------------------------------------------------------
// size_string_to_bytes
// parses a decimal size token with optional sign, fraction and k/m/g suffix
// into a byte count and a status, one character item at a time
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata: char_code; tlast: last_char; tuser: empty_token
//  m_axis    out        tdata: byte_count, status
//  cfg       in         cfg_data_i: max_size
//
//  a character item is taken while the parser is idle; the last one is followed by the
//  shared shift-subtract divider (shift s = 0, 10, 20 or 30 by suffix)
//  and a final stage of scaling and limit compare; an empty token skips the divider
//  the result waits in an output register while new characters are taken
//  the final stage repeats while the previous result has not been taken
//  reset clears the token state and loads max_size with 2^30
`timescale 1ns / 1ps

module size_string_to_bytes import sstb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [CHAR_W-1:0]     s_axis_tdata,   // [7:0] char_code
  input  logic                  s_axis_tlast,
  input  logic                  s_axis_tuser,   // [0] empty_token
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [62:0] byte_count, [65:63] status
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [COUNT_W-1:0]    cfg_data_i
);

  fsm_e                  fsm_q, fsm_d;
  phase_e                phase_q, phase_d;
  logic [COUNT_W-1:0]    whole_q, whole_d;
  logic                  wovf_q, wovf_d;
  logic [FRAC_W-1:0]     frac_q, frac_d;
  logic [DIGCNT_W-1:0]   fdig_q, fdig_d;
  logic                  neg_q, neg_d;
  logic [SHIFT_W-1:0]    shift_q, shift_d;
  logic                  bad_q, bad_d;
  logic [COUNT_W-1:0]    max_size_q;
  logic [FRAC_W-1:0]     num_q, num_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [QUO_W-1:0]      quo_q, quo_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic                  ovalid_q, ovalid_d;
  logic [COUNT_W-1:0]    ocount_q, ocount_d;
  status_e               ostat_q, ostat_d;

  logic                  in_acc;
  logic [CHAR_W-1:0]     c;
  logic                  is_digit;
  logic [3:0]            dval;
  logic [SHIFT_W-1:0]    sfx;
  logic [COUNT_W+3:0]    wide;
  logic [FRAC_W-1:0]     den;
  logic [REM_W-1:0]      rem2;
  logic                  ge;
  logic [STEP_W-1:0]     last_step;
  logic [FRAC_W-1:0]     total;
  logic [COUNT_W-1:0]    whole_hi;
  status_e               st;

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (fsm_q == FSM_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {6'b0, ostat_q, ocount_q};
  assign cfg_ready_o   = 1'b1;

  assign c        = s_axis_tdata;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dval     = 4'(c - CH_ZERO);
  assign wide     = ({4'b0, whole_q} << 3) + ({4'b0, whole_q} << 1) + (COUNT_W+4)'(dval);

  always_comb begin
    if (c == CH_UK || c == CH_LK) begin
      sfx = SHIFT_K;
    end else if (c == CH_UM || c == CH_LM) begin
      sfx = SHIFT_M;
    end else if (c == CH_UG || c == CH_LG) begin
      sfx = SHIFT_G;
    end else begin
      sfx = '0;
    end
  end

  // shared divider step: frac * 2^s / 10^digits, one bit per cycle
  assign den       = pow10(fdig_q);
  assign rem2      = {rem_q[REM_W-2:0], num_q[FRAC_W-1]};
  assign ge        = {3'b0, rem2} >= den;
  assign last_step = STEP_W'(FRAC_W - 1) + STEP_W'(shift_q);

  assign whole_hi = whole_q >> (6'(COUNT_W) - 6'(shift_q));
  assign total    = ({1'b0, whole_q} << shift_q) + FRAC_W'(quo_q);

  always_comb begin
    if (bad_q || !(phase_q == PH_WHOLE || phase_q == PH_FRAC || phase_q == PH_SUFFIX)) begin
      st = ST_MALFORMED;
    end else if (neg_q || (!wovf_q && whole_q == '0 && frac_q == '0)) begin
      st = ST_NOT_POS;
    end else if (shift_q == '0 && frac_q != '0) begin
      st = ST_FRAC_NOSF;
    end else if (wovf_q) begin
      st = ST_TOO_LARGE;
    end else if (shift_q != '0 && whole_hi != '0) begin
      st = ST_TOO_LARGE;
    end else if (total > {1'b0, max_size_q}) begin
      st = ST_TOO_LARGE;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    fsm_d    = fsm_q;
    phase_d  = phase_q;
    whole_d  = whole_q;
    wovf_d   = wovf_q;
    frac_d   = frac_q;
    fdig_d   = fdig_q;
    neg_d    = neg_q;
    shift_d  = shift_q;
    bad_d    = bad_q;
    num_d    = num_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    step_d   = step_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    ocount_d = ocount_q;
    ostat_d  = ostat_q;

    case (fsm_q)
      FSM_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            bad_d = 1'b1;
            fsm_d = FSM_FIN;
          end else begin
            if (!bad_q) begin
              if (phase_q == PH_START && (c == CH_PLUS || c == CH_MINUS)) begin
                neg_d   = (c == CH_MINUS);
                phase_d = PH_SIGNED;
              end else if (is_digit && (phase_q == PH_START || phase_q == PH_SIGNED ||
                                        phase_q == PH_WHOLE)) begin
                if (wide[COUNT_W+3:COUNT_W] != '0) begin
                  wovf_d = 1'b1;
                end else begin
                  whole_d = wide[COUNT_W-1:0];
                end
                phase_d = PH_WHOLE;
              end else if (c == CH_DOT && phase_q == PH_WHOLE) begin
                phase_d = PH_DOT;
              end else if (is_digit && (phase_q == PH_DOT || phase_q == PH_FRAC)) begin
                if (fdig_q < DIGCNT_W'(FRAC_DIGITS)) begin
                  frac_d = (frac_q << 3) + (frac_q << 1) + FRAC_W'(dval);
                  fdig_d = fdig_q + 1'b1;
                end
                phase_d = PH_FRAC;
              end else if (sfx != '0 && (phase_q == PH_WHOLE || phase_q == PH_FRAC)) begin
                shift_d = sfx;
                phase_d = PH_SUFFIX;
              end else begin
                bad_d = 1'b1;
              end
            end
            if (s_axis_tlast) begin
              num_d  = frac_d;
              rem_d  = '0;
              quo_d  = '0;
              step_d = '0;
              fsm_d  = FSM_DIV;
            end
          end
        end
      end
      FSM_DIV: begin
        num_d  = num_q << 1;
        rem_d  = ge ? REM_W'({3'b0, rem2} - den) : rem2;
        quo_d  = {quo_q[QUO_W-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == last_step) begin
          fsm_d = FSM_FIN;
        end
      end
      FSM_FIN: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          ostat_d  = st;
          ocount_d = (st == ST_OK) ? total[COUNT_W-1:0] : '0;
          phase_d  = PH_START;
          whole_d  = '0;
          wovf_d   = 1'b0;
          frac_d   = '0;
          fdig_d   = '0;
          neg_d    = 1'b0;
          shift_d  = '0;
          bad_d    = 1'b0;
          fsm_d    = FSM_IDLE;
        end
      end
      default: begin
        fsm_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q      <= FSM_IDLE;
      phase_q    <= PH_START;
      whole_q    <= '0;
      wovf_q     <= 1'b0;
      frac_q     <= '0;
      fdig_q     <= '0;
      neg_q      <= 1'b0;
      shift_q    <= '0;
      bad_q      <= 1'b0;
      step_q     <= '0;
      ovalid_q   <= 1'b0;
      max_size_q <= MAX_SIZE_RST;
    end else begin
      fsm_q    <= fsm_d;
      phase_q  <= phase_d;
      whole_q  <= whole_d;
      wovf_q   <= wovf_d;
      frac_q   <= frac_d;
      fdig_q   <= fdig_d;
      neg_q    <= neg_d;
      shift_q  <= shift_d;
      bad_q    <= bad_d;
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        max_size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    num_q    <= num_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    ocount_q <= ocount_d;
    ostat_q  <= ostat_d;
  end

endmodule
